/* src/spmq_pkg.sv */
// shared types and codes for the strict priority multi-level queue
`default_nettype none

package spmq_pkg;

   localparam int TAG_FIELD_BITS   = 16;
   localparam int LEVEL_FIELD_BITS = 3;
   localparam int TOTAL_FIELD_BITS = 10;
   localparam int STATUS_BITS      = 2;
   localparam int REQ_TDATA_BITS   = 24;
   localparam int RSP_TDATA_BITS   = 32;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE = 2'b01,
      STATE_READ = 2'b10
   } state_type;

endpackage

`default_nettype wire

/* src/spmq_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module spmq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 192
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire [WIDTH-1:0]              wr_data,
   input  wire                          rd_en,
   input  wire [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [WIDTH-1:0]             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* src/strict_priority_multi_queue.sv */
// strict priority multi-level request queue, top level
// enqueue: result in the cycle after accept, one item per cycle while the output drains
// dequeue: registered ram read in state READ, then output register; no new request in READ
// results wait in an output register; a new item is taken as the register drains
// reset is synchronous and clears pointers, counts, total and control state
// tag ram contents are not cleared and need no clearing pass
`default_nettype none

module strict_priority_multi_queue
   import spmq_pkg::*;
#(
   parameter int LEVELS      = 3,
   parameter int LEVEL_DEPTH = 64,
   parameter int TAG_BITS    = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire [REQ_TDATA_BITS-1:0]   req_tdata,  // priority_req[2:0], request_tag[18:3], zero pad
   input  wire [0:0]                  req_tuser,  // op[0]
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [RSP_TDATA_BITS-1:0]  rsp_tdata,  // out_tag[15:0], out_level[18:16],
                                                  // total_queued[28:19], zero pad
   output logic [STATUS_BITS-1:0]     rsp_tuser   // status[1:0]
);

   localparam int STORE_DEPTH = LEVELS * LEVEL_DEPTH;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int PTR_BITS    = (LEVEL_DEPTH > 2) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(LEVEL_DEPTH + 1);
   localparam int TOT_BITS    = $clog2(STORE_DEPTH + 1);
   localparam int LVL_BITS    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int TAG_W       = (TAG_BITS > TAG_FIELD_BITS) ? TAG_BITS : TAG_FIELD_BITS;
   localparam int TOT_W       = (TOT_BITS > TOTAL_FIELD_BITS) ? TOT_BITS : TOTAL_FIELD_BITS;
   localparam logic [PTR_BITS-1:0] PTR_LAST  = PTR_BITS'(LEVEL_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL  = CNT_BITS'(LEVEL_DEPTH);
   localparam logic [ADDR_BITS-1:0] LVL_SPAN = ADDR_BITS'(LEVEL_DEPTH);
   localparam logic [LVL_BITS-1:0] LVL_LAST  = LVL_BITS'(LEVELS - 1);

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_BITS'(1);
   endfunction

   state_type                      state_ff, state_in;
   logic [PTR_BITS-1:0]            head_ff [LEVELS];
   logic [PTR_BITS-1:0]            head_in [LEVELS];
   logic [PTR_BITS-1:0]            tail_ff [LEVELS];
   logic [PTR_BITS-1:0]            tail_in [LEVELS];
   logic [CNT_BITS-1:0]            count_ff [LEVELS];
   logic [CNT_BITS-1:0]            count_in [LEVELS];
   logic [TOT_BITS-1:0]            total_ff, total_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   status_type                     rsp_status_ff, rsp_status_in;
   logic [TAG_FIELD_BITS-1:0]      rsp_tag_ff, rsp_tag_in;
   logic [LEVEL_FIELD_BITS-1:0]    rsp_level_ff, rsp_level_in;
   logic [TOTAL_FIELD_BITS-1:0]    rsp_total_ff, rsp_total_in;

   logic                           req_accept;
   op_type                         req_op;
   logic [LEVEL_FIELD_BITS-1:0]    req_priority;
   logic [TAG_FIELD_BITS-1:0]      req_tag;
   logic [TAG_W-1:0]               req_tag_wide;
   logic [TAG_W-1:0]               rd_tag_wide;
   logic [TOT_W-1:0]               total_wide;

   logic                           ram_wr_en;
   logic [ADDR_BITS-1:0]           ram_wr_addr;
   logic                           ram_rd_en;
   logic [ADDR_BITS-1:0]           ram_rd_addr;
   logic [TAG_BITS-1:0]            ram_rd_data;

   assign req_op       = op_type'(req_tuser[0]);
   assign req_priority = req_tdata[2:0];
   assign req_tag      = req_tdata[18:3];
   assign req_tag_wide = TAG_W'(req_tag);
   assign rd_tag_wide  = TAG_W'(ram_rd_data);

   assign req_tready = (state_ff == STATE_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   spmq_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_tag_wide[TAG_BITS-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      logic [LVL_BITS-1:0] enq_lvl;
      logic [LVL_BITS-1:0] deq_lvl;
      logic                found;

      enq_lvl = (32'(req_priority) >= LEVELS) ? LVL_LAST : LVL_BITS'(req_priority);
      deq_lvl = '0;
      found   = 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            found   = 1'b1;
            deq_lvl = LVL_BITS'(i);
         end
      end

      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_total_in  = rsp_total_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_addr   = ADDR_BITS'(enq_lvl) * LVL_SPAN + ADDR_BITS'(tail_ff[enq_lvl]);
      ram_rd_addr   = ADDR_BITS'(deq_lvl) * LVL_SPAN + ADDR_BITS'(head_ff[deq_lvl]);

      if (req_accept) begin
         rsp_tag_in = '0;
         if (req_op == OP_ENQUEUE) begin
            rsp_valid_in = 1'b1;
            rsp_level_in = LEVEL_FIELD_BITS'(enq_lvl);
            if (count_ff[enq_lvl] == CNT_FULL) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               ram_wr_en         = 1'b1;
               tail_in[enq_lvl]  = ptr_next(tail_ff[enq_lvl]);
               count_in[enq_lvl] = count_ff[enq_lvl] + CNT_BITS'(1);
               total_in          = total_ff + TOT_BITS'(1);
               rsp_status_in     = STATUS_DONE;
            end
         end else if (found) begin
            ram_rd_en         = 1'b1;
            head_in[deq_lvl]  = ptr_next(head_ff[deq_lvl]);
            count_in[deq_lvl] = count_ff[deq_lvl] - CNT_BITS'(1);
            total_in          = total_ff - TOT_BITS'(1);
            rsp_status_in     = STATUS_DONE;
            rsp_level_in      = LEVEL_FIELD_BITS'(deq_lvl);
            state_in          = STATE_READ;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_EMPTY;
            rsp_level_in  = '0;
         end
      end

      total_wide   = TOT_W'(total_in);
      if (req_accept) begin
         rsp_total_in = total_wide[TOTAL_FIELD_BITS-1:0];
      end

      unique case (state_ff)
         STATE_IDLE: begin
         end
         STATE_READ: begin
            rsp_valid_in = 1'b1;
            rsp_tag_in   = rd_tag_wide[TAG_FIELD_BITS-1:0];
            state_in     = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_total_ff, rsp_level_ff, rsp_tag_ff};

endmodule

`default_nettype wire
